// ===== hdl/wof_pkg.sv =====
package wof_pkg;

   localparam int ANGLE_BITS      = 14;
   localparam int SINE_TABLE_BITS = 8;
   localparam int TBL_N           = 1 << SINE_TABLE_BITS;
   localparam int PH_W            = SINE_TABLE_BITS + 2;
   localparam int PHASE_SHIFT     = ANGLE_BITS - SINE_TABLE_BITS - 2;
   localparam int PH_R            = (PHASE_SHIFT > 0) ? PHASE_SHIFT : 0;
   localparam int PH_L            = (PHASE_SHIFT < 0) ? -PHASE_SHIFT : 0;
   localparam int NUM_W           = ANGLE_BITS + 36;
   localparam int DEN_W           = 26;
   localparam int STEP_W          = $clog2(NUM_W + 1);
   localparam int HALF_TURN       = 1 << (ANGLE_BITS - 1);

   localparam logic [15:0] ALPHA_ONE     = 16'd32768;
   localparam logic [15:0] ALPHA_RESET   = 16'd27853;
   localparam logic [15:0] GAIN_RESET    = 16'd16384;
   localparam logic [23:0] PERIOD_RESET  = 24'd16777;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_CLR_DIST  = 2'd1,
      OP_CLR_SPEED = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_ALPHA        = 3'd0,
      CSR_GAIN         = 3'd1,
      CSR_LEFT_SCALE   = 3'd2,
      CSR_RIGHT_SCALE  = 3'd3,
      CSR_LEFT_HARM    = 3'd4,
      CSR_RIGHT_HARM   = 3'd5,
      CSR_TICK_PERIOD  = 3'd6,
      CSR_SPARE        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                  operation;
      logic [ANGLE_BITS-1:0]       angle_right;
      logic [ANGLE_BITS-1:0]       angle_left;
      logic signed [23:0]          acceleration;
   } req_type;

   typedef struct packed {
      logic signed [23:0] raw_speed_left;
      logic signed [23:0] raw_speed_right;
      logic signed [39:0] raw_distance_left;
      logic signed [39:0] raw_distance_right;
      logic signed [23:0] smooth_speed_left;
      logic signed [23:0] smooth_speed_right;
      logic signed [39:0] smooth_distance_left;
      logic signed [39:0] smooth_distance_right;
      logic signed [23:0] fused_speed_left;
      logic signed [23:0] fused_speed_right;
      logic signed [39:0] fused_distance_left;
      logic signed [39:0] fused_distance_right;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic clr_dist;
      logic clr_speed;
      logic ack;
   } lane_ctrl_type;

   typedef struct packed {
      logic        negate;
      logic [15:0] alpha;
      logic [15:0] gain;
      logic [31:0] speed_scale;
      logic [63:0] harmonics;
      logic [23:0] tick_period;
   } lane_cfg_type;

   typedef struct packed {
      logic signed [23:0] raw;
      logic signed [39:0] raw_dist;
      logic signed [23:0] smooth;
      logic signed [39:0] smooth_dist;
      logic signed [23:0] fused;
      logic signed [39:0] fused_dist;
   } lane_res_type;

   typedef logic [15:0] sine_rom_type [TBL_N];

   // quarter-wave sine, Q1.15, odd-power Taylor series at the bin centres
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      for (int k = 0; k < TBL_N; k++) begin
         x    = (64'(2 * k + 1) * 64'd1686629713) / (2 * TBL_N);
         term = x;
         sum  = x;
         for (int n = 1; n <= 7; n++) begin
            term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = v[15:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   function automatic logic [PH_W-1:0] phase_of(logic [ANGLE_BITS-1:0] angle);
      logic [31:0] e;
      e = 32'(angle);
      e = (e >> PH_R) << PH_L;
      return e[PH_W-1:0];
   endfunction

   function automatic logic signed [16:0] trig(logic [PH_W-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] q;
      logic signed [16:0]         v;
      q = ph[SINE_TABLE_BITS-1:0];
      v = ph[PH_W-2] ? signed'({1'b0, SINE_ROM[~q]}) : signed'({1'b0, SINE_ROM[q]});
      return ph[PH_W-1] ? -v : v;
   endfunction

   function automatic logic signed [23:0] sat24(logic signed [63:0] x);
      if (x > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (x < -64'sd8388608) begin
         return 24'sh800000;
      end
      return x[23:0];
   endfunction

   // distance gain of one tick, rounded half up, wrapping at 40 bits
   function automatic logic signed [39:0] dist_step(logic signed [39:0] d,
                                                    logic signed [61:0] p);
      logic signed [63:0] s;
      s = (64'(p) + 64'sd8388608) >>> 24;
      s = 64'(d) + s;
      return s[39:0];
   endfunction

endpackage

// ===== hdl/wof_lane.sv =====
module wof_lane import wof_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  lane_ctrl_type          ctrl,
   input  lane_cfg_type           cfg,
   input  logic [ANGLE_BITS-1:0]  angle,
   input  logic signed [23:0]     acceleration,
   output logic                   done,
   output lane_res_type           res
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MULT = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FILT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [61:0]       prod_ff, prod_in;
   logic signed [35:0]       sum_ff, sum_in;
   logic signed [NUM_W:0]    num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [NUM_W-1:0]         nmag_ff, nmag_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic signed [23:0]       raw_ff, raw_in;
   logic signed [ANGLE_BITS:0] delta_ff, delta_in;
   logic [ANGLE_BITS-1:0]    ang_ff, ang_in;
   logic signed [23:0]       acc_ff, acc_in;
   logic [ANGLE_BITS-1:0]    last_ff, last_in;
   logic signed [63:0]       tmp_ff, tmp_in;
   logic signed [35:0]       p8_ff, p8_in;
   logic signed [39:0]       raw_dist_ff, raw_dist_in;
   logic signed [23:0]       smooth_ff, smooth_in;
   logic signed [39:0]       smooth_dist_ff, smooth_dist_in;
   logic signed [23:0]       fused_ff, fused_in;
   logic signed [39:0]       fused_dist_ff, fused_dist_in;

   logic signed [35:0]       mul_a;
   logic signed [25:0]       mul_b;
   logic [PH_W-1:0]          ph;
   logic [15:0]              one_m_alpha;
   logic signed [ANGLE_BITS+1:0] dw;
   logic signed [63:0]       wide;
   logic [DEN_W:0]           trial;
   logic [NUM_W-1:0]         qmax;

   assign ph          = phase_of(ang_ff);
   assign one_m_alpha = ALPHA_ONE - cfg.alpha;
   assign prod_in     = mul_a * mul_b;
   assign qmax        = NUM_W'(24'h7FFFFF);

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      sum_in         = sum_ff;
      num_in         = num_ff;
      neg_in         = neg_ff;
      den_in         = den_ff;
      nmag_in        = nmag_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      raw_in         = raw_ff;
      delta_in       = delta_ff;
      ang_in         = ang_ff;
      acc_in         = acc_ff;
      last_in        = last_ff;
      tmp_in         = tmp_ff;
      p8_in          = p8_ff;
      raw_dist_in    = raw_dist_ff;
      smooth_in      = smooth_ff;
      smooth_dist_in = smooth_dist_ff;
      fused_in       = fused_ff;
      fused_dist_in  = fused_dist_ff;
      mul_a          = '0;
      mul_b          = '0;
      dw             = '0;
      wide           = '0;
      trial          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               if (cfg.negate) begin
                  dw = signed'({2'b00, last_ff}) - signed'({2'b00, angle});
               end else begin
                  dw = signed'({2'b00, angle}) - signed'({2'b00, last_ff});
               end
               if (dw > (ANGLE_BITS+2)'(HALF_TURN)) begin
                  dw = dw - (ANGLE_BITS+2)'(2 * HALF_TURN);
               end else if (dw < -(ANGLE_BITS+2)'(HALF_TURN)) begin
                  dw = dw + (ANGLE_BITS+2)'(2 * HALF_TURN);
               end
               delta_in = dw[ANGLE_BITS:0];
               last_in  = angle;
               ang_in   = angle;
               acc_in   = acceleration;
               step_in  = '0;
               state_in = ST_MULT;
            end
            if (ctrl.clr_dist) begin
               raw_dist_in    = '0;
               smooth_dist_in = '0;
               fused_dist_in  = '0;
            end
            if (ctrl.clr_speed) begin
               smooth_in = '0;
               fused_in  = '0;
            end
         end
         ST_MULT: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               STEP_W'(0): begin
                  mul_a = 36'(signed'(cfg.harmonics[15:0]));
                  mul_b = 26'(trig(ph));
               end
               STEP_W'(1): begin
                  mul_a  = 36'(signed'(cfg.harmonics[31:16]));
                  mul_b  = 26'(trig(ph + PH_W'(TBL_N)));
                  sum_in = 36'(prod_ff);
               end
               STEP_W'(2): begin
                  mul_a  = 36'(signed'(cfg.harmonics[47:32]));
                  mul_b  = 26'(trig({ph[PH_W-2:0], 1'b0}));
                  sum_in = sum_ff + 36'(prod_ff);
               end
               STEP_W'(3): begin
                  mul_a  = 36'(signed'(cfg.harmonics[63:48]));
                  mul_b  = 26'(trig({ph[PH_W-2:0], 1'b0} + PH_W'(TBL_N)));
                  sum_in = sum_ff + 36'(prod_ff);
               end
               STEP_W'(4): begin
                  mul_a  = 36'(cfg.speed_scale);
                  mul_b  = 26'(delta_ff);
                  sum_in = sum_ff + 36'(prod_ff);
               end
               STEP_W'(5): begin
                  mul_a  = sum_ff;
                  mul_b  = 26'(cfg.gain);
                  wide   = 64'(prod_ff) <<< 4;
                  num_in = wide[NUM_W:0];
               end
               default: begin
                  // denominator in Q20, clamped to stay positive
                  wide = 64'sd1048576 + (64'(prod_ff) >>> 24);
                  if (wide < 64'sd1) begin
                     wide = 64'sd1;
                  end
                  den_in  = wide[DEN_W-1:0];
                  neg_in  = num_ff[NUM_W];
                  nmag_in = num_ff[NUM_W] ? NUM_W'(-num_ff) : num_ff[NUM_W-1:0];
                  rem_in  = '0;
                  quo_in  = '0;
                  step_in = '0;
                  state_in = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff < STEP_W'(NUM_W)) begin
               trial   = {rem_ff, nmag_ff[NUM_W-1]};
               nmag_in = {nmag_ff[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = DEN_W'(trial - {1'b0, den_ff});
                  quo_in = {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[DEN_W-1:0];
                  quo_in = {quo_ff[NUM_W-2:0], 1'b0};
               end
            end else begin
               if (neg_ff) begin
                  raw_in = (quo_ff > qmax) ? 24'sh800000 : 24'(-signed'({1'b0, quo_ff}));
               end else begin
                  raw_in = (quo_ff > qmax) ? 24'sh7FFFFF : quo_ff[23:0];
               end
               step_in  = '0;
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               STEP_W'(0): begin
                  mul_a = 36'(cfg.tick_period);
                  mul_b = 26'(raw_ff);
               end
               STEP_W'(1): begin
                  raw_dist_in = dist_step(raw_dist_ff, prod_ff);
                  mul_a = 36'(smooth_ff);
                  mul_b = 26'(cfg.alpha);
               end
               STEP_W'(2): begin
                  tmp_in = 64'(prod_ff);
                  mul_a  = 36'(raw_ff);
                  mul_b  = 26'(one_m_alpha);
               end
               STEP_W'(3): begin
                  wide      = (tmp_ff + 64'(prod_ff) + 64'sd16384) >>> 15;
                  smooth_in = sat24(wide);
                  mul_a     = 36'(cfg.tick_period);
                  mul_b     = 26'(acc_ff);
               end
               STEP_W'(4): begin
                  wide  = ((64'(fused_ff) <<< 24) + 64'(prod_ff)) >>> 16;
                  p8_in = wide[35:0];
                  mul_a = 36'(cfg.tick_period);
                  mul_b = 26'(smooth_ff);
               end
               STEP_W'(5): begin
                  smooth_dist_in = dist_step(smooth_dist_ff, prod_ff);
                  mul_a = p8_ff;
                  mul_b = 26'(cfg.alpha);
               end
               STEP_W'(6): begin
                  tmp_in = 64'(prod_ff);
                  mul_a  = 36'(raw_ff) <<< 8;
                  mul_b  = 26'(one_m_alpha);
               end
               STEP_W'(7): begin
                  wide     = (tmp_ff + 64'(prod_ff) + 64'sd4194304) >>> 23;
                  fused_in = sat24(wide);
               end
               STEP_W'(8): begin
                  mul_a = 36'(cfg.tick_period);
                  mul_b = 26'(fused_ff);
               end
               default: begin
                  fused_dist_in = dist_step(fused_dist_ff, prod_ff);
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_ff        <= '0;
         raw_dist_ff    <= '0;
         smooth_ff      <= '0;
         smooth_dist_ff <= '0;
         fused_ff       <= '0;
         fused_dist_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         last_ff        <= last_in;
         raw_dist_ff    <= raw_dist_in;
         smooth_ff      <= smooth_in;
         smooth_dist_ff <= smooth_dist_in;
         fused_ff       <= fused_in;
         fused_dist_ff  <= fused_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      nmag_ff  <= nmag_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      raw_ff   <= raw_in;
      delta_ff <= delta_in;
      ang_ff   <= ang_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      p8_ff    <= p8_in;
   end

   assign done            = (state_ff == ST_DONE);
   assign res.raw         = raw_ff;
   assign res.raw_dist    = raw_dist_ff;
   assign res.smooth      = smooth_ff;
   assign res.smooth_dist = smooth_dist_ff;
   assign res.fused       = fused_ff;
   assign res.fused_dist  = fused_dist_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == ST_IDLE)
      else $error("lane started while busy");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0)
      else $error("zero divisor in divide");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !ctrl.ack) |=> state_ff == ST_DONE)
      else $error("lane result dropped before ack");
`endif

endmodule

// ===== hdl/wof_merge.sv =====
module wof_merge import wof_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          tick,
   input  lane_res_type  res_left,
   input  lane_res_type  res_right,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   output logic          ready
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in                      = 1'b1;
         data_in.raw_speed_left        = tick ? res_left.raw : '0;
         data_in.raw_speed_right       = tick ? res_right.raw : '0;
         data_in.raw_distance_left     = res_left.raw_dist;
         data_in.raw_distance_right    = res_right.raw_dist;
         data_in.smooth_speed_left     = res_left.smooth;
         data_in.smooth_speed_right    = res_right.smooth;
         data_in.smooth_distance_left  = res_left.smooth_dist;
         data_in.smooth_distance_right = res_right.smooth_dist;
         data_in.fused_speed_left      = res_left.fused;
         data_in.fused_speed_right     = res_right.fused;
         data_in.fused_distance_left   = res_left.fused_dist;
         data_in.fused_distance_right  = res_right.fused_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/wheel_odometry_fusion.sv =====
// Two-wheel encoder odometry: one request transfer in, one response transfer
// out. A tick request runs six multiply steps for the harmonic correction and
// count scaling, one quotient bit per cycle for the speed divide, then ten
// filter and distance steps, all on one registered 36 x 26 multiplier per
// wheel. Both wheels run in their own lane at once. A new request is taken
// once the previous one has reached the output register; the response waits
// there while the next request runs. The sine table is a constant ROM, so
// there is no start-up sweep after reset.
module wheel_odometry_fusion import wof_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration registers
   logic [15:0] alpha_ff, alpha_in;
   logic [15:0] gain_ff, gain_in;
   logic [31:0] lscale_ff, lscale_in;
   logic [31:0] rscale_ff, rscale_in;
   logic [63:0] lharm_ff, lharm_in;
   logic [63:0] rharm_ff, rharm_in;
   logic [23:0] period_ff, period_in;

   // request bookkeeping
   logic busy_ff, busy_in;
   logic tick_ff, tick_in;

   logic          accept;
   logic          finish;
   logic          merge_ready;
   logic          done_left, done_right;
   logic [15:0]   alpha_eff;
   lane_ctrl_type ctrl;
   lane_cfg_type  cfg_left, cfg_right;
   lane_res_type  res_left, res_right;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   // the response register must be free; a tick also waits for both lanes
   assign finish = busy_ff && merge_ready && (!tick_ff || (done_left && done_right));

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   assign ctrl.start     = accept && (req_data.operation == OP_TICK);
   assign ctrl.clr_dist  = accept && (req_data.operation == OP_CLR_DIST);
   assign ctrl.clr_speed = accept && (req_data.operation == OP_CLR_SPEED);
   assign ctrl.ack       = finish && tick_ff;

   // left wheel counts the other way round
   assign cfg_left.negate       = 1'b1;
   assign cfg_left.alpha        = alpha_eff;
   assign cfg_left.gain         = gain_ff;
   assign cfg_left.speed_scale  = lscale_ff;
   assign cfg_left.harmonics    = lharm_ff;
   assign cfg_left.tick_period  = period_ff;
   assign cfg_right.negate      = 1'b0;
   assign cfg_right.alpha       = alpha_eff;
   assign cfg_right.gain        = gain_ff;
   assign cfg_right.speed_scale = rscale_ff;
   assign cfg_right.harmonics   = rharm_ff;
   assign cfg_right.tick_period = period_ff;

   always_comb begin
      alpha_in  = alpha_ff;
      gain_in   = gain_ff;
      lscale_in = lscale_ff;
      rscale_in = rscale_ff;
      lharm_in  = lharm_ff;
      rharm_in  = rharm_ff;
      period_in = period_ff;
      busy_in   = busy_ff;
      tick_in   = tick_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHA:       alpha_in  = csr_wdata[15:0];
            CSR_GAIN:        gain_in   = csr_wdata[15:0];
            CSR_LEFT_SCALE:  lscale_in = csr_wdata[31:0];
            CSR_RIGHT_SCALE: rscale_in = csr_wdata[31:0];
            CSR_LEFT_HARM:   lharm_in  = csr_wdata;
            CSR_RIGHT_HARM:  rharm_in  = csr_wdata;
            CSR_TICK_PERIOD: period_in = csr_wdata[23:0];
            default: ;
         endcase
      end
      // clear requests also restore the filter weight; a distance clear also restores the gain
      if (ctrl.clr_dist) begin
         alpha_in = ALPHA_RESET;
         gain_in  = GAIN_RESET;
      end
      if (ctrl.clr_speed) begin
         alpha_in = ALPHA_RESET;
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         tick_in = (req_data.operation == OP_TICK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         gain_ff   <= GAIN_RESET;
         lscale_ff <= '0;
         rscale_ff <= '0;
         lharm_ff  <= '0;
         rharm_ff  <= '0;
         period_ff <= PERIOD_RESET;
         busy_ff   <= 1'b0;
         tick_ff   <= 1'b0;
      end else begin
         alpha_ff  <= alpha_in;
         gain_ff   <= gain_in;
         lscale_ff <= lscale_in;
         rscale_ff <= rscale_in;
         lharm_ff  <= lharm_in;
         rharm_ff  <= rharm_in;
         period_ff <= period_in;
         busy_ff   <= busy_in;
         tick_ff   <= tick_in;
      end
   end

   wof_lane u_lane_left (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg_left),
      .angle        (req_data.angle_left),
      .acceleration (req_data.acceleration),
      .done         (done_left),
      .res          (res_left)
   );

   wof_lane u_lane_right (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg_right),
      .angle        (req_data.angle_right),
      .acceleration (req_data.acceleration),
      .done         (done_right),
      .res          (res_right)
   );

   wof_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (finish),
      .tick      (tick_ff),
      .res_left  (res_left),
      .res_right (res_right),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ready     (merge_ready)
   );

`ifndef ASSERT_OFF
   a_tick_runs: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff && tick_ff && !done_left && !done_right)
      else $error("tick transfer did not start both lanes");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("request transfer not held busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
`endif

endmodule
